FILE: sv/aes_pkg.sv
// AES-128 package: payload structs, S-box tables and GF(2^8) helpers.
// Used by every module of the cipher block.
`default_nettype none
package aes_pkg;

   localparam int ROUNDS_DEFAULT = 10;

   localparam logic [0:0] ACTION_ENCRYPT = 1'b0;
   localparam logic [0:0] ACTION_DECRYPT = 1'b1;

   localparam logic CSR_KEY_UPPER = 1'b0;
   localparam logic CSR_KEY_LOWER = 1'b1;

   typedef struct packed {
      logic [0:0]  action;
      logic [63:0] block_upper;
      logic [63:0] block_lower;
   } req_type;

   typedef struct packed {
      logic [63:0] out_upper;
      logic [63:0] out_lower;
   } rsp_type;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xt(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] mul9(input logic [7:0] x);
      logic [7:0] x2, x4, x8;
      x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
      return x8 ^ x;
   endfunction

   function automatic logic [7:0] mulb(input logic [7:0] x);
      logic [7:0] x2, x4, x8;
      x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
      return x8 ^ x2 ^ x;
   endfunction

   function automatic logic [7:0] muld(input logic [7:0] x);
      logic [7:0] x2, x4, x8;
      x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
      return x8 ^ x4 ^ x;
   endfunction

   function automatic logic [7:0] mule(input logic [7:0] x);
      logic [7:0] x2, x4, x8;
      x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
      return x8 ^ x4 ^ x2;
   endfunction

   // Byte i of a 128-bit state, byte 0 most significant.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

endpackage
`default_nettype wire

FILE: sv/aes128_block_cipher_top.sv
// AES-128 ECB cipher, fully unrolled: one block per cycle when not stalled.
// Latency: the state is registered in every round stage between request acceptance and response valid.
// Throughput: one transaction per cycle when not stalled, set by the unrolled round chain.
// Reset: synchronous; clears the pipeline and expands the all-zero key; no request
// is accepted during the expansion. A key write re-expands the same way.
`default_nettype none
module aes128_block_cipher_top
   import aes_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [63:0]  key_upper_ff, key_lower_ff;
   logic [127:0] rkey [ROUNDS+1];
   logic         kbusy, kstart;
   logic         advance;
   logic         v [ROUNDS+1];
   logic         d [ROUNDS+1];
   logic [127:0] s [ROUNDS+1];
   logic         in_valid;
   logic [127:0] whitened;

   assign kstart = csr_write;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_UPPER: key_upper_ff <= csr_data;
            CSR_KEY_LOWER: key_lower_ff <= csr_data;
            default: ;
         endcase
      end
   end

   aes_keyexp #(.ROUNDS(ROUNDS)) u_keyexp (
      .clock (clock),
      .reset (reset),
      .start (kstart),
      .key   (csr_index == CSR_KEY_UPPER ? {csr_data, key_lower_ff}
                                          : {key_upper_ff, csr_data}),
      .rkey  (rkey),
      .busy  (kbusy)
   );

   // Pipeline moves whenever the output slot is free or being taken.
   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || kbusy || csr_write;
   assign in_valid = req_valid && !req_stall;

   assign whitened = {req_data.block_upper, req_data.block_lower}
                   ^ ((req_data.action == ACTION_DECRYPT) ? rkey[ROUNDS] : rkey[0]);
   assign v[0] = in_valid;
   assign d[0] = (req_data.action == ACTION_DECRYPT);
   assign s[0] = whitened;

   for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
      aes_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .last      (g == ROUNDS),
         .valid_in  (v[g-1]),
         .dec_in    (d[g-1]),
         .state_in  (s[g-1]),
         .key_enc   (rkey[g]),
         .key_dec   (rkey[ROUNDS-g]),
         .valid_out (v[g]),
         .dec_out   (d[g]),
         .state_out (s[g])
      );
   end

   assign rsp_valid = v[ROUNDS];
   assign rsp_data.out_upper = s[ROUNDS][127:64];
   assign rsp_data.out_lower = s[ROUNDS][63:0];
endmodule
`default_nettype wire

FILE: sv/aes_lane.sv
// One AES column lane: sub-bytes, column mix and round-key add on 32 bits.
// Depends on aes_pkg; four lanes make one round stage.
`default_nettype none
module aes_lane
   import aes_pkg::*;
(
   input  wire logic        decrypt,
   input  wire logic        last,
   input  wire logic [31:0] col_in,
   input  wire logic [31:0] key_col,
   output logic [31:0]      col_out
);
   logic [7:0] b [4];
   logic [7:0] m [4];
   logic [7:0] all;
   logic [31:0] keyed;

   // Encrypt: col_in is post-shift bytes; sub, mix, add key.
   // Decrypt: col_in is post-shift bytes; sub, add key, inverse mix. Last round: sub, add key.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         b[k] = decrypt ? INV_BOX[col_in[31 - 8*k -: 8]] : FWD_BOX[col_in[31 - 8*k -: 8]];
      end
      keyed = {b[0], b[1], b[2], b[3]} ^ key_col;
      all = b[0] ^ b[1] ^ b[2] ^ b[3];
      m[0] = b[0] ^ all ^ xt(b[0] ^ b[1]);
      m[1] = b[1] ^ all ^ xt(b[1] ^ b[2]);
      m[2] = b[2] ^ all ^ xt(b[2] ^ b[3]);
      m[3] = b[3] ^ all ^ xt(b[3] ^ b[0]);
      if (last) begin
         col_out = keyed;
      end else if (!decrypt) begin
         col_out = {m[0], m[1], m[2], m[3]} ^ key_col;
      end else begin
         col_out[31:24] = mule(keyed[31:24]) ^ mulb(keyed[23:16])
                        ^ muld(keyed[15:8]) ^ mul9(keyed[7:0]);
         col_out[23:16] = mul9(keyed[31:24]) ^ mule(keyed[23:16])
                        ^ mulb(keyed[15:8]) ^ muld(keyed[7:0]);
         col_out[15:8]  = muld(keyed[31:24]) ^ mul9(keyed[23:16])
                        ^ mule(keyed[15:8]) ^ mulb(keyed[7:0]);
         col_out[7:0]   = mulb(keyed[31:24]) ^ muld(keyed[23:16])
                        ^ mul9(keyed[15:8]) ^ mule(keyed[7:0]);
      end
   end
endmodule
`default_nettype wire

FILE: sv/aes_keyexp.sv
// Round-key expansion: one key round per cycle after reset or a key register write.
// Depends on aes_pkg; feeds the round keys to the pipeline stages.
`default_nettype none
module aes_keyexp
   import aes_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [127:0]   key,
   output logic [127:0]        rkey [ROUNDS+1],
   output logic                busy
);
   localparam int CW = $clog2(ROUNDS + 1);

   logic [127:0]  rkey_ff [ROUNDS+1];
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic          busy_ff, busy_in;
   logic [127:0]  prev, nxt;
   logic [31:0]   t, w0, w1, w2, w3;

   always_comb begin
      prev = rkey_ff[idx_ff];
      t = {FWD_BOX[prev[23:16]], FWD_BOX[prev[15:8]], FWD_BOX[prev[7:0]],
           FWD_BOX[prev[31:24]]} ^ {rcon_ff, 24'h0};
      w0 = prev[127:96] ^ t;
      w1 = prev[95:64] ^ w0;
      w2 = prev[63:32] ^ w1;
      w3 = prev[31:0] ^ w2;
      nxt = {w0, w1, w2, w3};
      busy_in = busy_ff;
      idx_in = idx_ff;
      rcon_in = rcon_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in = '0;
         rcon_in = 8'h01;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         rcon_in = xt(rcon_ff);
         if (idx_ff == CW'(ROUNDS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff <= '0;
         rcon_ff <= 8'h01;
         rkey_ff[0] <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         rcon_ff <= rcon_in;
         if (start) rkey_ff[0] <= key;
         else if (busy_ff) rkey_ff[idx_ff + 1'b1] <= nxt;
      end
   end

   assign rkey = rkey_ff;
   assign busy = busy_ff;
endmodule
`default_nettype wire

FILE: sv/aes_round.sv
// One pipeline round stage: shift rows, four column lanes, registered state.
// Depends on aes_pkg and aes_lane.
`default_nettype none
module aes_round
   import aes_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         last,
   input  wire logic         valid_in,
   input  wire logic         dec_in,
   input  wire logic [127:0] state_in,
   input  wire logic [127:0] key_enc,
   input  wire logic [127:0] key_dec,
   output logic              valid_out,
   output logic              dec_out,
   output logic [127:0]      state_out
);
   logic [127:0] shifted, mixed, kdec;
   logic         valid_ff, dec_ff;
   logic [127:0] state_ff;

   // Decrypt key is not pre-mixed with InvMix(x^k) = InvMix(x)^InvMix(k): the lane
   // adds the key before the inverse mix, so the raw key is used.
   assign kdec = key_dec;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (dec_in)
               shifted[127 - 8*(r + 4*((c + r) % 4)) -: 8] = get_byte(state_in, r + 4*c);
            else
               shifted[127 - 8*(r + 4*c) -: 8] = get_byte(state_in, r + 4*((c + r) % 4));
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      aes_lane u_lane (
         .decrypt (dec_in),
         .last    (last),
         .col_in  (shifted[127 - 32*g -: 32]),
         .key_col (dec_in ? kdec[127 - 32*g -: 32] : key_enc[127 - 32*g -: 32]),
         .col_out (mixed[127 - 32*g -: 32])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
         state_ff <= mixed;
      end
   end

   assign valid_out = valid_ff;
   assign dec_out = dec_ff;
   assign state_out = state_ff;
endmodule
`default_nettype wire

FILE: sv/aes_checker.sv
// Port-level checker for the AES-128 cipher top level, bound in below.
// Depends on aes_pkg for the payload types.
`default_nettype none
module aes_checker
   import aes_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data,
   input wire logic    csr_write
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request dropped while stalled");
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> req_stall)
      else $error("request accepted during key write");
   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("request accepted during key expansion");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind aes128_block_cipher_top aes_checker u_aes_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_write (csr_write)
);
`default_nettype wire
